// ===== hw/rtl/i2cms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Command codes, phase numbers and the sequencer state record.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_START     = 3'd1,
        KIND_STOP      = 3'd2,
        KIND_WRITE     = 3'd3,
        KIND_READ      = 3'd4,
        KIND_SEND_ACK  = 3'd5,
        KIND_SEND_NACK = 3'd6,
        KIND_READ_ACK  = 3'd7
    } kind_t;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_SECOND = 3'd1;
    localparam logic [2:0] PH_THIRD  = 3'd2;
    localparam logic [2:0] PH_FOURTH = 3'd3;

    localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd50;

    // cmd == KIND_TICK means idle
    typedef struct packed {
        kind_t       cmd;
        logic [2:0]  phase;
        logic [3:0]  bit_idx;
        logic [7:0]  shift;
        logic [15:0] ticks;
        logic        scl_low;
        logic        sda_low;
        logic        ack;
        logic [7:0]  read_hold;
    } seq_state_t;

endpackage : i2cms_pkg
`default_nettype wire

// ===== hw/rtl/i2cms_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master sequencer step
// Next state and done flag for one beat: command launch or one tick.
// ----------------------------------------------------------------------------
module i2cms_step
    import i2cms_pkg::*;
(
    input  wire seq_state_t  cur,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        sda_in,
    input  wire logic [15:0] half_period,
    output seq_state_t  nxt,
    output logic        done
);

    kind_t       kind_k;
    logic [16:0] ticks_inc;
    logic [16:0] period;
    logic [3:0]  bit_inc;
    logic [7:0]  shifted;
    logic        finished;

    assign kind_k = kind_t'(kind);

    always_comb
    begin
        nxt       = cur;
        done      = 1'b0;
        finished  = 1'b0;
        ticks_inc = {1'b0, cur.ticks} + 17'd1;
        period    = (half_period == 16'd0) ? 17'd1 : {1'b0, half_period};
        bit_inc   = cur.bit_idx + 4'd1;
        shifted   = {cur.shift[6:0], 1'b0};

        if (cur.cmd == KIND_TICK)
        begin
            if (kind_k != KIND_TICK)
            begin
                nxt.cmd     = kind_k;
                nxt.phase   = PH_FIRST;
                nxt.bit_idx = 4'd0;
                nxt.ticks   = 16'd0;
                case (kind_k)
                    KIND_START:
                    begin
                        nxt.scl_low = 1'b0;
                        nxt.sda_low = 1'b0;
                    end
                    KIND_STOP, KIND_SEND_ACK:
                    begin
                        nxt.scl_low = 1'b1;
                        nxt.sda_low = 1'b1;
                    end
                    KIND_WRITE:
                    begin
                        nxt.shift   = data_byte;
                        nxt.scl_low = 1'b1;
                        nxt.sda_low = ~data_byte[7];
                    end
                    KIND_READ:
                    begin
                        nxt.shift = 8'd0;
                    end
                    KIND_SEND_NACK:
                    begin
                        nxt.scl_low = 1'b1;
                        nxt.sda_low = 1'b0;
                    end
                    default:
                    begin
                        nxt.scl_low = 1'b0;
                        nxt.sda_low = 1'b0;
                    end
                endcase
            end
        end
        else if (kind_k == KIND_TICK)
        begin
            if (ticks_inc >= period)
            begin
                nxt.ticks = 16'd0;
                case (cur.cmd)
                    KIND_START:
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            nxt.phase   = PH_SECOND;
                            nxt.scl_low = 1'b0;
                            nxt.sda_low = 1'b1;
                        end
                        else
                        begin
                            finished = 1'b1;
                        end
                    end
                    KIND_STOP:
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            nxt.phase   = PH_SECOND;
                            nxt.scl_low = 1'b0;
                            nxt.sda_low = 1'b1;
                        end
                        else if (cur.phase == PH_SECOND)
                        begin
                            nxt.phase   = PH_THIRD;
                            nxt.scl_low = 1'b0;
                            nxt.sda_low = 1'b0;
                        end
                        else
                        begin
                            finished = 1'b1;
                        end
                    end
                    KIND_WRITE:
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            nxt.phase   = PH_SECOND;
                            nxt.scl_low = 1'b0;
                        end
                        else if (cur.phase == PH_SECOND)
                        begin
                            nxt.shift   = shifted;
                            nxt.bit_idx = bit_inc;
                            nxt.scl_low = 1'b1;
                            if (bit_inc < BITS_PER_BYTE)
                            begin
                                nxt.phase   = PH_FIRST;
                                nxt.sda_low = ~shifted[7];
                            end
                            else
                            begin
                                nxt.phase = PH_THIRD;
                            end
                        end
                        else
                        begin
                            finished = 1'b1;
                        end
                    end
                    KIND_READ:
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            nxt.phase   = PH_SECOND;
                            nxt.sda_low = 1'b0;
                        end
                        else if (cur.phase == PH_SECOND)
                        begin
                            nxt.phase   = PH_THIRD;
                            nxt.scl_low = 1'b0;
                            nxt.sda_low = 1'b0;
                        end
                        else if (cur.phase == PH_THIRD)
                        begin
                            // sample at the end of SCL high
                            nxt.shift   = {cur.shift[6:0], sda_in};
                            nxt.phase   = PH_FOURTH;
                            nxt.scl_low = 1'b1;
                            nxt.sda_low = 1'b0;
                        end
                        else
                        begin
                            nxt.bit_idx = bit_inc;
                            if (bit_inc < BITS_PER_BYTE)
                            begin
                                nxt.phase   = PH_THIRD;
                                nxt.scl_low = 1'b0;
                                nxt.sda_low = 1'b0;
                            end
                            else
                            begin
                                nxt.read_hold = cur.shift;
                                finished      = 1'b1;
                            end
                        end
                    end
                    KIND_SEND_ACK, KIND_SEND_NACK:
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            nxt.phase   = PH_SECOND;
                            nxt.scl_low = 1'b0;
                        end
                        else if (cur.phase == PH_SECOND)
                        begin
                            nxt.phase   = PH_THIRD;
                            nxt.scl_low = 1'b1;
                        end
                        else
                        begin
                            finished = 1'b1;
                        end
                    end
                    KIND_READ_ACK:
                    begin
                        if (cur.phase == PH_FIRST)
                        begin
                            nxt.ack     = sda_in;
                            nxt.phase   = PH_SECOND;
                            nxt.scl_low = 1'b1;
                            nxt.sda_low = 1'b0;
                        end
                        else
                        begin
                            finished = 1'b1;
                        end
                    end
                    default:
                    begin
                        finished = 1'b1;
                    end
                endcase

                if (finished)
                begin
                    nxt.cmd     = KIND_TICK;
                    nxt.phase   = PH_FIRST;
                    nxt.bit_idx = 4'd0;
                    done        = 1'b1;
                end
            end
            else
            begin
                nxt.ticks = ticks_inc[15:0];
            end
        end
    end

endmodule : i2cms_step
`default_nettype wire

// ===== hw/rtl/i2c_master_sequencer.sv =====
`default_nettype none
// Results are registered in the cycle after their input beat is taken.
// Throughput: one input beat per cycle; the result register frees up in the
// same cycle it is drained, so a stall only holds the input side while the
// result register is full and not taken.
// Reset: asynchronous, active low; idle, both lines released, ACK sample 1,
// half period 50 ticks.
// ----------------------------------------------------------------------------
// I2C master sequencer
// Open-drain SCL/SDA phase sequencer driven by tick and command beats.
// ----------------------------------------------------------------------------
module i2c_master_sequencer
    import i2cms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: half period in ticks
    input  wire logic        cfg_write_en,
    input  wire logic [15:0] cfg_write_data,
    // input beats
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        sda_in,
    // result beats
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        scl_low,
    output      logic        sda_low,
    output      logic        busy_res,
    output      logic        done_res,
    output      logic [7:0]  read_data,
    output      logic        ack_bit
);

    logic [15:0] half_period_reg;
    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic        done_next;
    logic        out_valid_reg;
    logic        accept;

    // result register
    logic        scl_low_reg;
    logic        sda_low_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [7:0]  read_data_reg;
    logic        ack_reg;

    // take a beat whenever the result register is empty or being drained
    assign in_ready = ~out_valid_reg | out_ready;
    assign accept   = in_valid & in_ready;

    i2cms_step u_step (
        .cur         (state_reg),
        .kind        (kind),
        .data_byte   (data_byte),
        .sda_in      (sda_in),
        .half_period (half_period_reg),
        .nxt         (state_next),
        .done        (done_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RST;
        end
        else if (cfg_write_en)
        begin
            half_period_reg <= cfg_write_data;
        end
    end

    // sequencer state advances only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.cmd       <= KIND_TICK;
            state_reg.phase     <= PH_FIRST;
            state_reg.bit_idx   <= 4'd0;
            state_reg.shift     <= 8'd0;
            state_reg.ticks     <= 16'd0;
            state_reg.scl_low   <= 1'b0;
            state_reg.sda_low   <= 1'b0;
            state_reg.ack       <= 1'b1;
            state_reg.read_hold <= 8'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload: no reset needed, qualified by out_valid
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_low_reg   <= state_next.scl_low;
            sda_low_reg   <= state_next.sda_low;
            busy_reg      <= (state_next.cmd != KIND_TICK);
            done_reg      <= done_next;
            read_data_reg <= state_next.read_hold;
            ack_reg       <= state_next.ack;
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_low   = scl_low_reg;
    assign sda_low   = sda_low_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign read_data = read_data_reg;
    assign ack_bit   = ack_reg;

endmodule : i2c_master_sequencer
`default_nettype wire
